@@ rtl/tcbb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbb_pkg
// Shared types and constants of the text cell block blitter.
// ----------------------------------------------------------------------------
package tcbb_pkg;

  localparam int MaxCols   = 128;
  localparam int MaxRows   = 64;
  localparam int ColW      = $clog2(MaxCols);
  localparam int RowW      = $clog2(MaxRows);
  localparam int AddrW     = ColW + RowW;
  localparam int CellW     = 16;
  localparam logic [7:0] BlankGlyph = 8'd32;

  localparam logic [3:0] CmdWrite    = 4'd0;
  localparam logic [3:0] CmdRead     = 4'd1;
  localparam logic [3:0] CmdMirTab   = 4'd2;
  localparam logic [3:0] CmdFlipTab  = 4'd3;
  localparam logic [3:0] CmdMirror   = 4'd4;
  localparam logic [3:0] CmdFlip     = 4'd5;
  localparam logic [3:0] CmdErase    = 4'd6;
  localparam logic [3:0] CmdFill     = 4'd7;
  localparam logic [3:0] CmdCapture  = 4'd8;
  localparam logic [3:0] CmdStamp    = 4'd9;

  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  localparam logic [1:0] RegCols  = 2'd0;
  localparam logic [1:0] RegRows  = 2'd1;
  localparam logic [1:0] RegErase = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,      // latch command fields and sort corners
    OpRdA,       // read frame at cursor A
    OpRdB,       // read frame at cursor B, hold A data
    OpMap,       // look up the glyph table for the B data, hold the read data
    OpWrA,       // write cursor A with processed value
    OpWrB,       // write cursor B with remapped A data
    OpRdClip,    // read clip at position counter
    OpWrClip,    // write clip with frame data
    OpWrStamp,   // conditional stamp write
    OpStep,      // advance cursors
    OpSetClip,   // latch clip size
    OpSingle     // single-cell command finish
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       empty_clip;
    logic       bad_range;
    logic       pair_live;  // cursor A still left of (above) cursor B
    logic       row_last;   // inner sweep has no further pair in this line
    logic       col_last;   // cursor at end of a line (linear commands)
    logic       line_last;  // last line
  } dp_stat_t;

endpackage

@@ rtl/tcbb_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbb_datapath
// Frame and clip memories, glyph tables, cursors and cell arithmetic.
// ----------------------------------------------------------------------------
module tcbb_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcbb_pkg::dp_cmd_t      ctl_i,
  output tcbb_pkg::dp_stat_t     stat_o,
  input  logic [3:0]             cmd_i,
  input  logic [6:0]             col_a_i,
  input  logic [5:0]             row_a_i,
  input  logic [6:0]             col_b_i,
  input  logic [5:0]             row_b_i,
  input  logic [15:0]            cell_value_i,
  input  logic [15:0]            fill_mask_i,
  input  logic [1:0]             stamp_mode_i,
  input  logic [7:0]             glyph_index_i,
  input  logic [7:0]             glyph_value_i,
  input  logic [7:0]             cols_i,
  input  logic [6:0]             rows_i,
  input  logic [15:0]            erase_cell_i,
  output logic [15:0]            read_data_o
);
  import tcbb_pkg::*;

  logic [CellW-1:0] frame_mem [2**AddrW];
  logic [CellW-1:0] clip_mem  [2**AddrW];
  logic [7:0] mir_mem [256];
  logic [7:0] flp_mem [256];
  logic [255:0] mir_vld_q, flp_vld_q;

  logic [3:0] cmd_q;
  logic [15:0] val_q, mask_q;
  logic [1:0] mode_q;
  logic [7:0] gidx_q, gval_q;
  logic [ColW-1:0] x1_q, x2_q, ja_q, kb_q;
  logic [RowW-1:0] y1_q, y2_q, ia_q, ib_q;
  logic [AddrW-1:0] pos_q;
  logic [7:0] clip_w_q;
  logic [6:0] clip_h_q;
  logic [CellW-1:0] rd_q, hold_q, crd_q;
  logic bad_q, empty_q;
  logic [15:0] read_data_q;

  // Limits are the smaller of register and build size.
  logic [8:0] col_lim;
  logic [7:0] row_lim;
  assign col_lim = ({1'b0, cols_i} < 9'(MaxCols)) ? {1'b0, cols_i} : 9'(MaxCols);
  assign row_lim = ({1'b0, rows_i} < 8'(MaxRows)) ? {1'b0, rows_i} : 8'(MaxRows);

  logic [8:0] se_col;
  logic [7:0] se_row;
  assign se_col = 9'(col_a_i) + 9'(clip_w_q) - 9'd1;
  assign se_row = 8'(row_a_i) + 8'(clip_h_q) - 8'd1;

  logic ok_a, ok_b, ok_se;
  assign ok_a  = (9'(col_a_i) < col_lim) && (8'(row_a_i) < row_lim);
  assign ok_b  = (9'(col_b_i) < col_lim) && (8'(row_b_i) < row_lim);
  assign ok_se = (se_col < col_lim) && (se_row < row_lim);

  logic bad_in;
  always_comb begin
    case (cmd_i)
      CmdWrite, CmdRead: bad_in = !ok_a;
      CmdMirror, CmdFlip, CmdErase, CmdFill, CmdCapture: bad_in = !(ok_a && ok_b);
      CmdStamp: bad_in = !(ok_a && ok_se);
      default: bad_in = 1'b0;
    endcase
  end

  // Cursor addresses: mirror walks ja/kb on row ia; flip walks ia/ib on column ja.
  // Single-cell commands use cursor A at the addressed cell.
  logic [AddrW-1:0] addr_a, addr_b, addr_s;
  always_comb begin
    if (cmd_q == CmdFlip) begin
      addr_a = {ia_q, ja_q};
      addr_b = {ib_q, ja_q};
    end else begin
      addr_a = {ia_q, ja_q};
      addr_b = {ia_q, kb_q};
    end
    addr_s = {ia_q, ja_q};
  end

  // The glyph table lookup is registered and is indexed by the B data during the map cycle,
  // then by the held A data during the write of cursor A.
  logic [7:0] tab_idx;
  logic [7:0] tab_q;
  assign tab_idx = (ctl_i.op == OpMap) ? rd_q[7:0] : hold_q[7:0];

  logic [15:0] wr_a_val;
  always_comb begin
    case (cmd_q)
      CmdErase: wr_a_val = erase_cell_i;
      CmdFill:  wr_a_val = (rd_q & ~mask_q) | (mask_q & val_q);
      default:  wr_a_val = {rd_q[15:8], tab_q};
    endcase
  end

  logic stamp_we;
  always_comb begin
    case (mode_q)
      2'd0:    stamp_we = 1'b1;
      2'd1:    stamp_we = (rd_q[7:0] == BlankGlyph);
      2'd2:    stamp_we = (crd_q[7:0] != BlankGlyph);
      default: stamp_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      OpSingle: begin
        if (!bad_q && cmd_q == CmdWrite) frame_mem[addr_a] <= val_q;
      end
      OpWrA:     frame_mem[addr_a] <= wr_a_val;
      OpWrB:     frame_mem[addr_b] <= {hold_q[15:8], tab_q};
      OpWrStamp: if (stamp_we) frame_mem[addr_s] <= crd_q;
      default: ;
    endcase
    if (ctl_i.op != OpMap) rd_q <= frame_mem[(ctl_i.op == OpRdB) ? addr_b : addr_a];
    crd_q <= clip_mem[pos_q];
    if (cmd_q == CmdMirror) begin
      tab_q <= mir_vld_q[tab_idx] ? mir_mem[tab_idx] : tab_idx;
    end else begin
      tab_q <= flp_vld_q[tab_idx] ? flp_mem[tab_idx] : tab_idx;
    end
    if (ctl_i.op == OpWrClip) clip_mem[pos_q] <= rd_q;
    if (ctl_i.op == OpRdB) hold_q <= rd_q;
    if (ctl_i.op == OpSingle && cmd_q == CmdMirTab) mir_mem[gidx_q] <= gval_q;
    if (ctl_i.op == OpSingle && cmd_q == CmdFlipTab) flp_mem[gidx_q] <= gval_q;
  end

  logic lin;
  assign lin = (cmd_q == CmdErase) || (cmd_q == CmdFill) || (cmd_q == CmdCapture)
               || (cmd_q == CmdStamp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mir_vld_q <= '0;
      flp_vld_q <= '0;
      clip_w_q <= '0;
      clip_h_q <= '0;
      cmd_q <= '0;
      bad_q <= 1'b0;
      empty_q <= 1'b0;
      read_data_q <= '0;
    end else begin
      unique case (ctl_i.op)
        OpLoad: begin
          cmd_q <= cmd_i;
          val_q <= cell_value_i;
          mask_q <= fill_mask_i;
          mode_q <= stamp_mode_i;
          gidx_q <= glyph_index_i;
          gval_q <= glyph_value_i;
          bad_q <= bad_in;
          empty_q <= (clip_w_q == 8'd0) || (clip_h_q == 7'd0);
          pos_q <= '0;
          read_data_q <= '0;
          if (cmd_i inside {CmdStamp, CmdWrite, CmdRead}) begin
            x1_q <= ColW'(col_a_i);
            x2_q <= ColW'(se_col);
            y1_q <= RowW'(row_a_i);
            y2_q <= RowW'(se_row);
            ja_q <= ColW'(col_a_i);
            ia_q <= RowW'(row_a_i);
          end else begin
            x1_q <= (col_a_i < col_b_i) ? col_a_i : col_b_i;
            x2_q <= (col_a_i < col_b_i) ? col_b_i : col_a_i;
            y1_q <= (row_a_i < row_b_i) ? row_a_i : row_b_i;
            y2_q <= (row_a_i < row_b_i) ? row_b_i : row_a_i;
            ja_q <= (col_a_i < col_b_i) ? col_a_i : col_b_i;
            kb_q <= (col_a_i < col_b_i) ? col_b_i : col_a_i;
            ia_q <= (row_a_i < row_b_i) ? row_a_i : row_b_i;
            ib_q <= (row_a_i < row_b_i) ? row_b_i : row_a_i;
          end
        end
        OpStep: begin
          pos_q <= pos_q + 1'b1;
          if (lin) begin
            if (ja_q == x2_q) begin
              ja_q <= x1_q;
              ia_q <= ia_q + 1'b1;
            end else begin
              ja_q <= ja_q + 1'b1;
            end
          end else if (cmd_q == CmdMirror) begin
            if (!(ja_q + 1'b1 < kb_q - 1'b1) || (ja_q >= kb_q)) begin
              ja_q <= x1_q;
              kb_q <= x2_q;
              ia_q <= ia_q + 1'b1;
            end else begin
              ja_q <= ja_q + 1'b1;
              kb_q <= kb_q - 1'b1;
            end
          end else begin
            if (!(ia_q + 1'b1 < ib_q - 1'b1) || (ia_q >= ib_q)) begin
              ia_q <= y1_q;
              ib_q <= y2_q;
              ja_q <= ja_q + 1'b1;
            end else begin
              ia_q <= ia_q + 1'b1;
              ib_q <= ib_q - 1'b1;
            end
          end
        end
        OpSetClip: begin
          clip_w_q <= 8'(x2_q - x1_q) + 8'd1;
          clip_h_q <= 7'(y2_q - y1_q) + 7'd1;
        end
        OpSingle: begin
          read_data_q <= (cmd_q == CmdRead && !bad_q) ? rd_q : 16'd0;
          if (cmd_q == CmdMirTab) mir_vld_q[gidx_q] <= 1'b1;
          if (cmd_q == CmdFlipTab) flp_vld_q[gidx_q] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign read_data_o = read_data_q;

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.empty_clip = empty_q;
    stat_o.bad_range  = bad_q;
    stat_o.pair_live  = (cmd_q == CmdFlip) ? (ia_q < ib_q) : (ja_q < kb_q);
    stat_o.col_last   = (ja_q == x2_q);
    stat_o.line_last  = (cmd_q == CmdFlip) ? (ja_q == x2_q) : (ia_q == y2_q);
    stat_o.row_last   = (cmd_q == CmdFlip) ? !(ia_q + 1'b1 < ib_q - 1'b1) || (ia_q >= ib_q)
                                           : !(ja_q + 1'b1 < kb_q - 1'b1) || (ja_q >= kb_q);
  end

endmodule

@@ rtl/tcbb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbb_ctrl
// Command sequencer: accepts an item, walks its cells, presents the result.
// ----------------------------------------------------------------------------
module tcbb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output tcbb_pkg::dp_cmd_t  ctl_o,
  input  tcbb_pkg::dp_stat_t stat_i
);
  import tcbb_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SDecode, SRdA, SRdB, SMap, SWrA, SWrB, SRdClip, SWrClip, SStamp,
    SStep, SSingle, SDone
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  dp_op_e op;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle) && out_free;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d = status_q;
    op = OpNone;
    unique case (state_q)
      SIdle: if (in_valid_i && out_free) begin
        op = OpLoad;
        state_d = SDecode;
      end
      SDecode: begin
        state_d = SDone;
        status_d = StDone;
        if (stat_i.cmd == CmdStamp && stat_i.empty_clip) begin
          status_d = StEmpty;
        end else if (stat_i.bad_range) begin
          status_d = StRange;
          if (stat_i.cmd == CmdRead || stat_i.cmd == CmdWrite) state_d = SSingle;
        end else begin
          case (stat_i.cmd)
            CmdWrite, CmdRead, CmdMirTab, CmdFlipTab: state_d = SSingle;
            CmdMirror, CmdFlip: state_d = stat_i.pair_live ? SRdA : SStep;
            CmdErase: state_d = SWrA;
            CmdFill, CmdCapture, CmdStamp: state_d = SRdA;
            default: state_d = SDone;
          endcase
        end
      end
      SSingle: begin
        op = OpSingle;
        state_d = SDone;
      end
      SRdA: begin
        op = OpRdA;
        if (stat_i.cmd == CmdMirror || stat_i.cmd == CmdFlip) state_d = SRdB;
        else if (stat_i.cmd == CmdCapture) state_d = SWrClip;
        else if (stat_i.cmd == CmdStamp) state_d = SRdClip;
        else state_d = SWrA;
      end
      SRdB: begin
        op = OpRdB;
        state_d = SMap;
      end
      SMap: begin
        op = OpMap;
        state_d = SWrA;
      end
      SRdClip: begin
        op = OpRdClip;
        state_d = SStamp;
      end
      SStamp: begin
        op = OpWrStamp;
        state_d = SStep;
      end
      SWrClip: begin
        op = OpWrClip;
        state_d = SStep;
      end
      SWrA: begin
        op = OpWrA;
        if (stat_i.cmd == CmdMirror || stat_i.cmd == CmdFlip) state_d = SWrB;
        else state_d = SStep;
      end
      SWrB: begin
        op = OpWrB;
        state_d = SStep;
      end
      SStep: begin
        if (stat_i.cmd == CmdMirror || stat_i.cmd == CmdFlip) begin
          if (stat_i.row_last && stat_i.line_last) begin
            state_d = SDone;
          end else begin
            op = OpStep;
            state_d = SDecode;
          end
        end else if (stat_i.col_last && stat_i.line_last) begin
          if (stat_i.cmd == CmdCapture) op = OpSetClip;
          state_d = SDone;
        end else begin
          op = OpStep;
          state_d = (stat_i.cmd == CmdErase) ? SWrA : SRdA;
        end
      end
      SDone: begin
        out_valid_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      out_valid_q <= 1'b0;
      status_q <= StDone;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign ctl_o.op = op;

endmodule

@@ rtl/text_cell_block_blitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_block_blitter
// Rectangle blitter for a character-cell text screen.
// ----------------------------------------------------------------------------
// Each command item returns exactly one result item. Single-cell and table
// commands pass decode and a single-cell step before the result. Rectangle
// commands walk their cells through the frame memory: erase writes each cell,
// fill reads and writes it, capture copies it to the clip, stamp reads it and
// the clip and writes it if the mode allows, and mirror and flip read, remap
// and write both cells of each pair and step over lines with no pair to swap.
// The next item is taken only in the idle state with the result register free,
// at the earliest in the same cycle in which the previous result leaves.
module text_cell_block_blitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, low to high: cmd[3:0], col_a[10:4], row_a[16:11], col_b[23:17],
  // row_b[29:24], cell_value[45:30], fill_mask[61:46], stamp_mode[63:62],
  // glyph_index[71:64], glyph_value[79:72]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, low to high: read_data[15:0], status[17:16], zero fill
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import tcbb_pkg::*;

  logic [7:0] cols_q;
  logic [6:0] rows_q;
  logic [15:0] erase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 8'd80;
      rows_q <= 7'd25;
      erase_q <= 16'd1824;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCols:  cols_q <= cfg_wdata_i[7:0];
        RegRows:  rows_q <= cfg_wdata_i[6:0];
        RegErase: erase_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dp_cmd_t ctl;
  dp_stat_t stat;
  logic [15:0] read_data;
  logic [1:0] status;

  tcbb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(status), .ctl_o(ctl), .stat_i(stat)
  );

  tcbb_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .stat_o(stat),
    .cmd_i(s_axis_tdata[3:0]), .col_a_i(s_axis_tdata[10:4]),
    .row_a_i(s_axis_tdata[16:11]), .col_b_i(s_axis_tdata[23:17]),
    .row_b_i(s_axis_tdata[29:24]), .cell_value_i(s_axis_tdata[45:30]),
    .fill_mask_i(s_axis_tdata[61:46]), .stamp_mode_i(s_axis_tdata[63:62]),
    .glyph_index_i(s_axis_tdata[71:64]), .glyph_value_i(s_axis_tdata[79:72]),
    .cols_i(cols_q), .rows_i(rows_q), .erase_cell_i(erase_q),
    .read_data_o(read_data)
  );

  assign m_axis_tdata = {6'd0, status, read_data};

`ifndef SYNTHESIS
  // A new item is never taken while a result is stuck at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");
  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");
`endif

endmodule
